// File: rtl/flvah_pkg.sv
// Shared types and constants for the FLV video to Annex-B H.264 demuxer.
// Holds the parse phase encoding and the result beat structures.
// Depends on nothing; used by flvah_parse and the top level.
package flvah_pkg;

  localparam logic [23:0] SigUpper   = 24'h464C56;
  localparam logic [23:0] SigLower   = 24'h666C76;
  localparam logic [7:0]  VideoTag   = 8'd9;
  localparam logic [7:0]  InfoKey    = 8'h17;
  localparam logic [7:0]  InfoInter  = 8'h27;
  localparam logic [31:0] FileHdrLen = 32'd9;
  localparam logic [3:0]  TagHdrLast = 4'd10;
  localparam logic [7:0]  AvcCfg     = 8'd0;
  localparam logic [7:0]  AvcNal     = 8'd1;
  localparam logic [1:0]  KindParam  = 2'd0;
  localparam logic [1:0]  KindKey    = 2'd1;
  localparam logic [1:0]  KindInter  = 2'd2;
  localparam logic [1:0]  KindOther  = 2'd3;
  localparam int unsigned MaxRes     = 4;
  localparam int unsigned ResCntW    = $clog2(MaxRes + 1);

  typedef enum logic [12:0] {
    PH_FILE   = 13'b0000000000001,
    PH_HSKIP  = 13'b0000000000010,
    PH_PREV   = 13'b0000000000100,
    PH_TAGHDR = 13'b0000000001000,
    PH_SKIP   = 13'b0000000010000,
    PH_VINFO  = 13'b0000000100000,
    PH_VAVC   = 13'b0000001000000,
    PH_CFGPRE = 13'b0000010000000,
    PH_NALPRE = 13'b0000100000000,
    PH_LEN2   = 13'b0001000000000,
    PH_LEN4   = 13'b0010000000000,
    PH_PPSNUM = 13'b0100000000000,
    PH_PAY    = 13'b1000000000000
  } phase_e;

  typedef struct packed {
    logic       bad;
    logic       eof;
    logic       first;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } res_item_t;

  typedef struct packed {
    logic [ResCntW-1:0]         cnt;
    res_item_t [MaxRes-1:0]     item;
  } res_grp_t;

endpackage

// File: rtl/flvah_parse.sv
// FLV parse state and the per-byte step logic of the demuxer.
// Produces the group of result beats that one accepted stream byte causes.
// Depends on flvah_pkg.
module flvah_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                sos_i,
  output flvah_pkg::res_grp_t res_o
);

  flvah_pkg::phase_e phase_q, phase_d, cur_phase;
  logic [3:0]  cnt_q, cnt_d, cur_cnt;
  logic [31:0] acc_q, acc_d, cur_acc;
  logic [31:0] hskip_q, hskip_d, cur_hskip;
  logic [7:0]  tkind_q, tkind_d, cur_tkind;
  logic [23:0] tbl_q, tbl_d, cur_tbl;
  logic [31:0] ubl_q, ubl_d, cur_ubl;
  logic [1:0]  ck_q, ck_d, cur_ck;
  logic        psp_q, psp_d, cur_psp;
  logic        fopen_q, fopen_d, cur_fopen;
  logic        halt_q, halt_d, cur_halt;

  always_comb begin
    if (sos_i) begin
      cur_phase = flvah_pkg::PH_FILE;
      cur_cnt   = '0;
      cur_acc   = '0;
      cur_hskip = '0;
      cur_tkind = '0;
      cur_tbl   = '0;
      cur_ubl   = '0;
      cur_ck    = flvah_pkg::KindOther;
      cur_psp   = 1'b0;
      cur_fopen = 1'b0;
      cur_halt  = 1'b0;
    end else begin
      cur_phase = phase_q;
      cur_cnt   = cnt_q;
      cur_acc   = acc_q;
      cur_hskip = hskip_q;
      cur_tkind = tkind_q;
      cur_tbl   = tbl_q;
      cur_ubl   = ubl_q;
      cur_ck    = ck_q;
      cur_psp   = psp_q;
      cur_fopen = fopen_q;
      cur_halt  = halt_q;
    end
  end

  always_comb begin
    logic [31:0] acc_n;
    logic [31:0] len;
    logic        sc;
    logic        ud;
    logic        fin;

    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    hskip_d = hskip_q;
    tkind_d = tkind_q;
    tbl_d   = tbl_q;
    ubl_d   = ubl_q;
    ck_d    = ck_q;
    psp_d   = psp_q;
    fopen_d = fopen_q;
    halt_d  = halt_q;
    res_o   = '0;
    acc_n   = '0;
    len     = '0;
    sc      = 1'b0;
    ud      = 1'b0;
    fin     = 1'b0;

    if (step_i) begin
      phase_d = cur_phase;
      cnt_d   = cur_cnt;
      acc_d   = cur_acc;
      hskip_d = cur_hskip;
      tkind_d = cur_tkind;
      tbl_d   = cur_tbl;
      ubl_d   = cur_ubl;
      ck_d    = cur_ck;
      psp_d   = cur_psp;
      fopen_d = cur_fopen;
      halt_d  = cur_halt;

      if (!cur_halt) begin
        unique case (cur_phase)
          flvah_pkg::PH_FILE: begin
            acc_n = cur_acc;
            if (cur_cnt < 4'd3) begin
              acc_n = {8'd0, cur_acc[15:0], byte_i};
            end
            acc_d = acc_n;
            if (cur_cnt == 4'd2 && acc_n[23:0] != flvah_pkg::SigUpper &&
                acc_n[23:0] != flvah_pkg::SigLower) begin
              halt_d = 1'b1;
              res_o.cnt = flvah_pkg::ResCntW'(1);
              res_o.item[0].bad  = 1'b1;
              res_o.item[0].kind = flvah_pkg::KindOther;
              res_o.item[0].last = 1'b1;
            end else begin
              if (cur_cnt == 4'd5) begin
                acc_n = {24'd0, byte_i};
              end else if (cur_cnt > 4'd5) begin
                acc_n = {acc_n[23:0], byte_i};
              end
              acc_d = acc_n;
              if (cur_cnt >= 4'd8) begin
                cnt_d = '0;
                if (acc_n > flvah_pkg::FileHdrLen) begin
                  hskip_d = acc_n - flvah_pkg::FileHdrLen;
                  phase_d = flvah_pkg::PH_HSKIP;
                end else begin
                  hskip_d = '0;
                  phase_d = flvah_pkg::PH_PREV;
                end
              end else begin
                cnt_d = cur_cnt + 4'd1;
              end
            end
          end
          flvah_pkg::PH_HSKIP: begin
            if (cur_hskip > 32'd1) begin
              hskip_d = cur_hskip - 32'd1;
            end else begin
              hskip_d = '0;
              phase_d = flvah_pkg::PH_PREV;
              cnt_d   = '0;
            end
          end
          flvah_pkg::PH_PREV: begin
            if (cur_cnt >= 4'd3) begin
              cnt_d   = '0;
              phase_d = flvah_pkg::PH_TAGHDR;
            end else begin
              cnt_d = cur_cnt + 4'd1;
            end
          end
          flvah_pkg::PH_TAGHDR: begin
            acc_n = cur_acc;
            if (cur_cnt == 4'd0) begin
              tkind_d = byte_i;
            end else if (cur_cnt == 4'd1) begin
              acc_n = {24'd0, byte_i};
            end else if (cur_cnt <= 4'd3) begin
              acc_n = {8'd0, cur_acc[15:0], byte_i};
            end
            acc_d = acc_n;
            if (cur_cnt >= flvah_pkg::TagHdrLast) begin
              cnt_d = '0;
              tbl_d = acc_n[23:0];
              if (acc_n[23:0] == 24'd0) begin
                phase_d = flvah_pkg::PH_PREV;
              end else if (cur_tkind == flvah_pkg::VideoTag) begin
                fopen_d = 1'b0;
                psp_d   = 1'b0;
                ck_d    = flvah_pkg::KindOther;
                phase_d = flvah_pkg::PH_VINFO;
              end else begin
                phase_d = flvah_pkg::PH_SKIP;
              end
            end else begin
              cnt_d = cur_cnt + 4'd1;
            end
          end
          default: begin
            if (cur_tbl != 24'd0) begin
              tbl_d = cur_tbl - 24'd1;
            end
            unique case (cur_phase)
              flvah_pkg::PH_VINFO: begin
                if (byte_i == flvah_pkg::InfoKey) begin
                  ck_d = flvah_pkg::KindKey;
                end else if (byte_i == flvah_pkg::InfoInter) begin
                  ck_d = flvah_pkg::KindInter;
                end else begin
                  ck_d = flvah_pkg::KindOther;
                end
                phase_d = flvah_pkg::PH_VAVC;
              end
              flvah_pkg::PH_VAVC: begin
                cnt_d = '0;
                if (byte_i == flvah_pkg::AvcCfg) begin
                  ck_d    = flvah_pkg::KindParam;
                  phase_d = flvah_pkg::PH_CFGPRE;
                end else if (byte_i == flvah_pkg::AvcNal) begin
                  phase_d = flvah_pkg::PH_NALPRE;
                end else begin
                  phase_d = flvah_pkg::PH_SKIP;
                end
              end
              flvah_pkg::PH_CFGPRE: begin
                if (cur_cnt >= 4'd8) begin
                  cnt_d   = '0;
                  phase_d = flvah_pkg::PH_LEN2;
                end else begin
                  cnt_d = cur_cnt + 4'd1;
                end
              end
              flvah_pkg::PH_NALPRE: begin
                if (cur_cnt >= 4'd2) begin
                  cnt_d   = '0;
                  phase_d = flvah_pkg::PH_LEN4;
                end else begin
                  cnt_d = cur_cnt + 4'd1;
                end
              end
              flvah_pkg::PH_LEN2: begin
                acc_n = (cur_cnt == 4'd0) ? {24'd0, byte_i} : {16'd0, cur_acc[7:0], byte_i};
                acc_d = acc_n;
                if (cur_cnt >= 4'd1) begin
                  cnt_d = '0;
                  sc    = 1'b1;
                  len   = acc_n;
                end else begin
                  cnt_d = cur_cnt + 4'd1;
                end
              end
              flvah_pkg::PH_LEN4: begin
                acc_n = (cur_cnt == 4'd0) ? {24'd0, byte_i} : {cur_acc[23:0], byte_i};
                acc_d = acc_n;
                if (cur_cnt >= 4'd3) begin
                  cnt_d = '0;
                  sc    = 1'b1;
                  len   = acc_n;
                end else begin
                  cnt_d = cur_cnt + 4'd1;
                end
              end
              flvah_pkg::PH_PPSNUM: begin
                cnt_d   = '0;
                phase_d = flvah_pkg::PH_LEN2;
              end
              flvah_pkg::PH_PAY: begin
                res_o.cnt = flvah_pkg::ResCntW'(1);
                res_o.item[0].data  = byte_i;
                res_o.item[0].kind  = cur_ck;
                res_o.item[0].first = !cur_fopen;
                fopen_d = 1'b1;
                if (cur_ubl > 32'd1) begin
                  ubl_d = cur_ubl - 32'd1;
                end else begin
                  ubl_d = '0;
                  ud    = 1'b1;
                end
              end
              default: begin
                phase_d = flvah_pkg::PH_SKIP;
              end
            endcase

            if (sc) begin
              res_o.cnt = flvah_pkg::ResCntW'(flvah_pkg::MaxRes);
              for (int i = 0; i < flvah_pkg::MaxRes; i++) begin
                res_o.item[i].kind = ck_d;
              end
              res_o.item[0].first = !cur_fopen;
              res_o.item[3].data  = 8'h01;
              fopen_d = 1'b1;
              ubl_d   = len;
              if (len == 32'd0) begin
                ud = 1'b1;
              end else begin
                phase_d = flvah_pkg::PH_PAY;
              end
            end

            if (ud) begin
              if (ck_d == flvah_pkg::KindParam) begin
                if (!cur_psp) begin
                  psp_d   = 1'b1;
                  phase_d = flvah_pkg::PH_PPSNUM;
                end else begin
                  phase_d = flvah_pkg::PH_SKIP;
                end
              end else begin
                phase_d = flvah_pkg::PH_LEN4;
                cnt_d   = '0;
              end
            end

            if (tbl_d == 24'd0) begin
              phase_d = flvah_pkg::PH_PREV;
              cnt_d   = '0;
            end

            priority case (phase_d)
              flvah_pkg::PH_PREV:   fin = 1'b1;
              flvah_pkg::PH_SKIP:   fin = 1'b1;
              flvah_pkg::PH_LEN4:   fin = (tbl_d < 24'd4);
              flvah_pkg::PH_PPSNUM: fin = (tbl_d < 24'd3);
              default:              fin = 1'b0;
            endcase

            if (sc) begin
              res_o.item[3].last = 1'b1;
              res_o.item[3].eof  = fin;
            end else if (res_o.cnt != '0) begin
              res_o.item[0].last = 1'b1;
              res_o.item[0].eof  = fin;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= flvah_pkg::PH_FILE;
      cnt_q   <= '0;
      acc_q   <= '0;
      hskip_q <= '0;
      tkind_q <= '0;
      tbl_q   <= '0;
      ubl_q   <= '0;
      ck_q    <= flvah_pkg::KindOther;
      psp_q   <= 1'b0;
      fopen_q <= 1'b0;
      halt_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      hskip_q <= hskip_d;
      tkind_q <= tkind_d;
      tbl_q   <= tbl_d;
      ubl_q   <= ubl_d;
      ck_q    <= ck_d;
      psp_q   <= psp_d;
      fopen_q <= fopen_d;
      halt_q  <= halt_d;
    end
  end

endmodule

// File: rtl/flv_video_to_annexb_h264_top.sv
// Top level of the FLV video to Annex-B H.264 demuxer: stream ports and result buffer.
// Instantiates flvah_parse; depends on flvah_pkg.
//
// The block takes one FLV stream byte per beat and returns the H.264 units of
// its video tags, each behind a four-byte start code. A byte that yields no
// output or one output byte is taken every cycle while the output side keeps
// up. A byte that completes a unit length yields four start-code beats; the
// four-entry buffer drains one beat per cycle while the output keeps up, so
// the input waits until its last beat drains. Beat counts from the parser set the rate.
module flv_video_to_annexb_h264_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tuser_i,   // [0] start_of_stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [4:0] m_axis_tuser_o,   // [1:0] frame_kind, [2] first_of_frame,
                                       // [3] end_of_frame, [4] bad_stream
  output logic       m_axis_tlast_o
);

  flvah_pkg::res_grp_t                    res;
  flvah_pkg::res_item_t [flvah_pkg::MaxRes-1:0] buf_q, buf_d;
  logic [flvah_pkg::ResCntW-1:0]          bcnt_q, bcnt_d;
  logic                                   in_fire, out_fire;

  assign m_axis_tvalid_o = (bcnt_q != '0);
  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (bcnt_q == '0) ||
                           (bcnt_q == flvah_pkg::ResCntW'(1) && m_axis_tready_i);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  flvah_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .byte_i (s_axis_tdata_i),
    .sos_i  (s_axis_tuser_i),
    .res_o  (res)
  );

  always_comb begin
    buf_d  = buf_q;
    bcnt_d = bcnt_q;
    if (in_fire) begin
      buf_d  = res.item;
      bcnt_d = res.cnt;
    end else if (out_fire) begin
      for (int i = 0; i < flvah_pkg::MaxRes - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      bcnt_d = bcnt_q - flvah_pkg::ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= '0;
    end else begin
      bcnt_q <= bcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign m_axis_tdata_o = buf_q[0].data;
  assign m_axis_tuser_o = {buf_q[0].bad, buf_q[0].eof, buf_q[0].first, buf_q[0].kind};
  assign m_axis_tlast_o = buf_q[0].last;

  a_bad_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && buf_q[0].bad |-> buf_q[0].last)
    else $error("bad_stream beat without last");

  a_last_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && buf_q[0].last |-> bcnt_q == flvah_pkg::ResCntW'(1))
    else $error("last beat is not the final buffered beat");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= flvah_pkg::ResCntW'(flvah_pkg::MaxRes))
    else $error("result buffer count out of range");

  a_burst_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res.cnt == flvah_pkg::ResCntW'(flvah_pkg::MaxRes) |=> !s_axis_tready_o)
    else $error("input taken while start code burst pending");

endmodule
